@@ hdl/a51kg_pkg.sv @@
// Types, constants and the control program of the A5/1 keystream generator.
`default_nettype none

package a51kg_pkg;

  localparam int unsigned KEY_BITS   = 64;
  localparam int unsigned FRAME_BITS = 22;
  localparam int unsigned MIX_STEPS  = 100;
  localparam int unsigned BURST_BITS = 228;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned FRAME_W = 22;
  localparam int unsigned R1_W    = 19;
  localparam int unsigned R2_W    = 22;
  localparam int unsigned R3_W    = 23;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned PC_W    = 3;
  localparam int unsigned OP_W    = 3;

  localparam int unsigned R1_CLK = 8;
  localparam int unsigned R2_CLK = 10;
  localparam int unsigned R3_CLK = 10;

  localparam logic [OP_W-1:0] OP_DISPATCH = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd1;
  localparam logic [OP_W-1:0] OP_KEY      = 3'd2;
  localparam logic [OP_W-1:0] OP_FRAME    = 3'd3;
  localparam logic [OP_W-1:0] OP_MIX      = 3'd4;

  localparam logic [PC_W-1:0] UPC_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] UPC_CLEAR = 3'd1;
  localparam logic [PC_W-1:0] UPC_KEY   = 3'd2;
  localparam logic [PC_W-1:0] UPC_FRAME = 3'd3;
  localparam logic [PC_W-1:0] UPC_MIX   = 3'd4;

  localparam logic [CNT_W-1:0] KEY_LOAD   = CNT_W'(KEY_BITS - 1);
  localparam logic [CNT_W-1:0] FRAME_LOAD = CNT_W'(FRAME_BITS - 1);
  localparam logic [CNT_W-1:0] MIX_LOAD   = CNT_W'((MIX_STEPS > 0) ? MIX_STEPS - 1 : 0);
  localparam logic [PC_W-1:0]  AFTER_FRAME = (MIX_STEPS > 0) ? UPC_MIX : UPC_IDLE;

  typedef struct packed {
    logic               kind;
    logic [FRAME_W-1:0] frame_number;
    logic               data_bit;
  } in_t;

  typedef struct packed {
    logic keystream_bit;
    logic out_bit;
    logic last_of_burst;
  } out_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             loop;
    logic [PC_W-1:0]  next_pc;
    logic [CNT_W-1:0] cnt_load;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      UPC_CLEAR: w = '{op: OP_CLEAR, loop: 1'b0, next_pc: UPC_KEY,     cnt_load: KEY_LOAD};
      UPC_KEY:   w = '{op: OP_KEY,   loop: 1'b1, next_pc: UPC_FRAME,   cnt_load: FRAME_LOAD};
      UPC_FRAME: w = '{op: OP_FRAME, loop: 1'b1, next_pc: AFTER_FRAME, cnt_load: MIX_LOAD};
      UPC_MIX:   w = '{op: OP_MIX,   loop: 1'b1, next_pc: UPC_IDLE,    cnt_load: '0};
      default:   w = '{op: OP_DISPATCH, loop: 1'b0, next_pc: UPC_IDLE, cnt_load: '0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/a51_keystream_generator_top.sv @@
// Top level of the A5/1 keystream generator: microcoded sequencer and LFSR datapath.
//
//   Channel  Direction  Handshake          Word
//   in       input      in_valid_i/stall   kind, frame_number, data_bit
//   out      output     out_valid_o/stall  keystream_bit, out_bit, last_of_burst
//   cfg      input      cfg_valid_i/ready  64-bit session key
//
// Data words stream at one per cycle while no start word is in progress and no held result is stalled.
// A start word runs the steps of the control program in order: dispatch, clear, key loading
// (64 bits), frame loading (22 bits) and 100 majority-clocked mixing steps.
// Reset clears the LFSR registers, the key, the burst position, the sequencer and the output valid.
// Input stalls while a start word is in progress or while a held result is not taken.
`default_nettype none

module a51_keystream_generator_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire a51kg_pkg::in_t               in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output a51kg_pkg::out_t                   out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [a51kg_pkg::KEY_W-1:0]  cfg_data_i
);
  import a51kg_pkg::*;

  logic [KEY_W-1:0]   key_q, key_d;
  logic [KEY_W-1:0]   key_sh_q, key_sh_d;
  logic [FRAME_W-1:0] frame_sh_q, frame_sh_d;
  logic [R1_W-1:0]    r1_q, r1_d;
  logic [R2_W-1:0]    r2_q, r2_d;
  logic [R3_W-1:0]    r3_q, r3_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [PC_W-1:0]    upc_q, upc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  ucode_t           uw;
  logic             in_acc;
  logic             fb1, fb2, fb3;
  logic             c1, c2, c3, maj;
  logic             all_in;
  logic [R1_W-1:0]  r1_all, r1_maj;
  logic [R2_W-1:0]  r2_all, r2_maj;
  logic [R3_W-1:0]  r3_all, r3_maj;
  logic [POS_W-1:0] pos_inc;
  logic             ks;

  assign uw          = ucode_rom(upc_q);
  assign in_stall_o  = (upc_q != UPC_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign fb1 = r1_q[18] ^ r1_q[17] ^ r1_q[16] ^ r1_q[13];
  assign fb2 = r2_q[21] ^ r2_q[20];
  assign fb3 = r3_q[22] ^ r3_q[21] ^ r3_q[20] ^ r3_q[7];

  assign c1  = r1_q[R1_CLK];
  assign c2  = r2_q[R2_CLK];
  assign c3  = r3_q[R3_CLK];
  assign maj = (c1 & c2) | (c1 & c3) | (c2 & c3);

  assign all_in = (uw.op == OP_KEY) ? key_sh_q[0] : frame_sh_q[0];
  assign r1_all = {r1_q[R1_W-2:0], fb1 ^ all_in};
  assign r2_all = {r2_q[R2_W-2:0], fb2 ^ all_in};
  assign r3_all = {r3_q[R3_W-2:0], fb3 ^ all_in};
  assign r1_maj = (c1 == maj) ? {r1_q[R1_W-2:0], fb1} : r1_q;
  assign r2_maj = (c2 == maj) ? {r2_q[R2_W-2:0], fb2} : r2_q;
  assign r3_maj = (c3 == maj) ? {r3_q[R3_W-2:0], fb3} : r3_q;

  assign ks      = r1_maj[R1_W-1] ^ r2_maj[R2_W-1] ^ r3_maj[R3_W-1];
  assign pos_inc = pos_q + POS_W'(1);

  always_comb begin
    key_d       = key_q;
    key_sh_d    = key_sh_q;
    frame_sh_d  = frame_sh_q;
    r1_d        = r1_q;
    r2_d        = r2_q;
    r3_d        = r3_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    upc_d       = upc_q;
    cnt_d       = cnt_q;

    if (cfg_valid_i && cfg_ready_o) begin
      key_d = cfg_data_i;
    end

    if (uw.loop && (cnt_q != '0)) begin
      cnt_d = cnt_q - CNT_W'(1);
    end else if (uw.op != OP_DISPATCH) begin
      upc_d = uw.next_pc;
      cnt_d = uw.cnt_load;
    end

    unique case (uw.op)
      OP_DISPATCH: begin
        if (in_acc) begin
          if (!in_data_i.kind) begin
            frame_sh_d = in_data_i.frame_number;
            upc_d      = UPC_CLEAR;
          end else begin
            r1_d                = r1_maj;
            r2_d                = r2_maj;
            r3_d                = r3_maj;
            out_valid_d         = 1'b1;
            out_d.keystream_bit = ks;
            out_d.out_bit       = ks ^ in_data_i.data_bit;
            if (pos_inc >= POS_W'(BURST_BITS)) begin
              out_d.last_of_burst = 1'b1;
              pos_d               = '0;
            end else begin
              out_d.last_of_burst = 1'b0;
              pos_d               = pos_inc;
            end
          end
        end
      end
      OP_CLEAR: begin
        r1_d     = '0;
        r2_d     = '0;
        r3_d     = '0;
        pos_d    = '0;
        key_sh_d = key_q;
      end
      OP_KEY: begin
        r1_d     = r1_all;
        r2_d     = r2_all;
        r3_d     = r3_all;
        key_sh_d = key_sh_q >> 1;
      end
      OP_FRAME: begin
        r1_d       = r1_all;
        r2_d       = r2_all;
        r3_d       = r3_all;
        frame_sh_d = frame_sh_q >> 1;
      end
      OP_MIX: begin
        r1_d = r1_maj;
        r2_d = r2_maj;
        r3_d = r3_maj;
      end
      default: begin
        upc_d = UPC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      r1_q        <= '0;
      r2_q        <= '0;
      r3_q        <= '0;
      pos_q       <= '0;
      upc_q       <= UPC_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      key_q       <= key_d;
      r1_q        <= r1_d;
      r2_q        <= r2_d;
      r3_q        <= r3_d;
      pos_q       <= pos_d;
      upc_q       <= upc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_sh_q   <= key_sh_d;
    frame_sh_q <= frame_sh_d;
    out_q      <= out_d;
  end

endmodule

`default_nettype wire

@@ sim/tb_a51_keystream_generator_top.sv @@
// Self-checking testbench for the A5/1 keystream generator with a built-in cipher predictor.
`timescale 1ns / 1ps

module tb_a51_keystream_generator_top;
  import a51kg_pkg::*;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;
  localparam int   GAP_PCT     = 12;
  localparam int   DRAIN_CYCLES = 250;
  localparam int   CYCLE_LIMIT  = 1000000;
  localparam int   PHASE_WORDS  = 330;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_t               in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_t              out_data_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [KEY_W-1:0]  cfg_data_i;

  in_t               word_q[$];
  out_t              keystream_q[$];
  logic [R1_W-1:0]   lfsr_a;
  logic [R2_W-1:0]   lfsr_b;
  logic [R3_W-1:0]   lfsr_c;
  logic [POS_W-1:0]  burst_pos;
  logic [KEY_W-1:0]  key_shadow;
  int                errors;
  int                cycle_cnt;
  bit                calm;
  bit                word_taken;

  a51_keystream_generator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic void clock_every(input logic feed);
    logic na, nb, nc;
    na = lfsr_a[18] ^ lfsr_a[17] ^ lfsr_a[16] ^ lfsr_a[13] ^ feed;
    nb = lfsr_b[21] ^ lfsr_b[20] ^ feed;
    nc = lfsr_c[22] ^ lfsr_c[21] ^ lfsr_c[20] ^ lfsr_c[7] ^ feed;
    lfsr_a = {lfsr_a[R1_W-2:0], na};
    lfsr_b = {lfsr_b[R2_W-2:0], nb};
    lfsr_c = {lfsr_c[R3_W-2:0], nc};
  endfunction

  function automatic void clock_majority();
    logic c1, c2, c3, maj, na, nb, nc;
    c1  = lfsr_a[R1_CLK];
    c2  = lfsr_b[R2_CLK];
    c3  = lfsr_c[R3_CLK];
    maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
    na  = lfsr_a[18] ^ lfsr_a[17] ^ lfsr_a[16] ^ lfsr_a[13];
    nb  = lfsr_b[21] ^ lfsr_b[20];
    nc  = lfsr_c[22] ^ lfsr_c[21] ^ lfsr_c[20] ^ lfsr_c[7];
    if (c1 == maj) lfsr_a = {lfsr_a[R1_W-2:0], na};
    if (c2 == maj) lfsr_b = {lfsr_b[R2_W-2:0], nb};
    if (c3 == maj) lfsr_c = {lfsr_c[R3_W-2:0], nc};
  endfunction

  function automatic logic advance_cipher(input in_t w, output out_t r);
    logic ks;
    r = '0;
    if (w.kind == KIND_START) begin
      lfsr_a    = '0;
      lfsr_b    = '0;
      lfsr_c    = '0;
      burst_pos = '0;
      for (int i = 0; i < KEY_BITS; i++) clock_every(key_shadow[i]);
      for (int i = 0; i < FRAME_BITS; i++) clock_every(w.frame_number[i]);
      for (int i = 0; i < MIX_STEPS; i++) clock_majority();
      return 1'b0;
    end
    clock_majority();
    ks = lfsr_a[R1_W-1] ^ lfsr_b[R2_W-1] ^ lfsr_c[R3_W-1];
    burst_pos = burst_pos + POS_W'(1);
    r.keystream_bit = ks;
    r.out_bit       = w.data_bit ^ ks;
    r.last_of_burst = 1'b0;
    if (burst_pos >= BURST_BITS) begin
      r.last_of_burst = 1'b1;
      burst_pos       = '0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
    errors++;
  endtask

  task automatic push_word(input logic k, input logic [FRAME_W-1:0] f, input logic d);
    in_t w;
    w.kind         = k;
    w.frame_number = f;
    w.data_bit     = d;
    word_q.push_back(w);
  endtask

  task automatic load_key(input logic [KEY_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    key_shadow = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic fill_random(input int n_words);
    int count, run, pick;
    count = 0;
    while (count < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        run = ($urandom_range(0, 2) == 0) ? $urandom_range(228, 480) : $urandom_range(1, 120);
        if (run > n_words - count - 1) run = n_words - count - 1;
        push_word(KIND_START, FRAME_W'($urandom), 1'($urandom));
        repeat (run) push_word(KIND_DATA, FRAME_W'($urandom), 1'($urandom));
        count += run + 1;
      end else if (pick < 90) begin
        push_word(KIND_START, FRAME_W'($urandom), 1'($urandom));
        push_word(KIND_START, FRAME_W'($urandom), 1'($urandom));
        count += 2;
      end else begin
        run = $urandom_range(1, 8);
        if (run > n_words - count) run = n_words - count;
        repeat (run) push_word(KIND_DATA, FRAME_W'($urandom), 1'($urandom));
        count += run;
      end
    end
  endtask

  task automatic drain();
    while (word_q.size() != 0 || in_valid_i || keystream_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!in_valid_i || word_taken) begin
      if (word_q.size() != 0 && (calm || $urandom_range(0, 99) >= GAP_PCT)) begin
        in_data_i  <= word_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && !calm && ($urandom_range(0, 99) < GAP_PCT);
  end

  always @(posedge clk_i) begin : monitor
    out_t predicted;
    out_t want;
    word_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        word_taken = 1'b1;
        if (advance_cipher(in_data_i, predicted)) keystream_q.push_back(predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        if (keystream_q.size() == 0) begin
          report_mismatch("unexpected output word", int'(out_data_o), 0);
        end else begin
          want = keystream_q.pop_front();
          if (out_data_o.keystream_bit !== want.keystream_bit)
            report_mismatch("keystream_bit", int'(out_data_o.keystream_bit),
                            int'(want.keystream_bit));
          if (out_data_o.out_bit !== want.out_bit)
            report_mismatch("out_bit", int'(out_data_o.out_bit), int'(want.out_bit));
          if (out_data_o.last_of_burst !== want.last_of_burst)
            report_mismatch("last_of_burst", int'(out_data_o.last_of_burst),
                            int'(want.last_of_burst));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    errors      = 0;
    cycle_cnt   = 0;
    calm        = 1'b0;
    word_taken  = 1'b0;
    lfsr_a      = '0;
    lfsr_b      = '0;
    lfsr_c      = '0;
    burst_pos   = '0;
    key_shadow  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Data words ahead of any frame start run on the cleared registers.
    push_word(KIND_DATA, '0, 1'b0);
    push_word(KIND_DATA, '1, 1'b1);
    push_word(KIND_DATA, '0, 1'b1);
    drain();
    load_key({$urandom, $urandom});
    push_word(KIND_START, '0, 1'b0);
    push_word(KIND_DATA, '0, 1'b0);
    push_word(KIND_DATA, '1, 1'b1);
    push_word(KIND_START, '1, 1'b1);
    push_word(KIND_DATA, '1, 1'b1);
    push_word(KIND_DATA, '0, 1'b0);
    push_word(KIND_START, FRAME_W'(1), 1'b0);
    push_word(KIND_DATA, '0, 1'b1);
    push_word(KIND_DATA, '0, 1'b0);
    push_word(KIND_START, FRAME_W'(1) << (FRAME_W - 1), 1'b1);
    push_word(KIND_DATA, '1, 1'b0);
    push_word(KIND_DATA, '1, 1'b1);
    push_word(KIND_START, FRAME_W'($urandom), 1'b0);
    push_word(KIND_START, FRAME_W'($urandom), 1'b1);
    push_word(KIND_DATA, FRAME_W'($urandom), 1'b1);
    drain();

    load_key('1);
    fill_random(PHASE_WORDS);
    drain();

    calm = 1'b1;
    load_key('0);
    fill_random(PHASE_WORDS);
    drain();
    calm = 1'b0;

    load_key(64'h8000_0000_0000_0001);
    fill_random(PHASE_WORDS);
    drain();

    repeat (2) begin
      load_key({$urandom, $urandom});
      fill_random(PHASE_WORDS);
      drain();
    end

    if (keystream_q.size() != 0)
      report_mismatch("words never delivered", 0, keystream_q.size());
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/a51kg_pkg.sv
hdl/a51_keystream_generator_top.sv
sim/tb_a51_keystream_generator_top.sv
